FILE: sv/cfd_pkg.sv
// shared types, constants and register indexes for the control frame deframer
// no dependencies
package cfd_pkg;

  localparam int HELD_LEN = 6;
  localparam int SUM_LEN  = 5;
  localparam int QPTR_W   = 1;

  localparam logic [2:0] CFG_HEADER  = 3'd0;
  localparam logic [2:0] CFG_FOOTER  = 3'd1;
  localparam logic [2:0] CFG_TIMEOUT = 3'd2;
  localparam logic [2:0] CFG_SPD_SCL = 3'd3;
  localparam logic [2:0] CFG_STR_SCL = 3'd4;

  localparam logic [7:0] HEADER_RST  = 8'hA5;
  localparam logic [7:0] FOOTER_RST  = 8'h5A;
  localparam logic [7:0] TIMEOUT_RST = 8'd100;
  localparam logic [23:0] SCALE_RST  = 24'd65536;

  localparam logic [1:0] KIND_TEXT    = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int FLAG_START = 0;
  localparam int FLAG_ESTOP = 1;
  localparam int FLAG_TELEM = 2;

  typedef logic [HELD_LEN-1:0][7:0] held_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] footer_byte;
    logic [7:0] timeout_ticks;
  } cfg_front_t;

  typedef struct packed {
    logic [23:0] speed_scale;
    logic [23:0] steer_scale;
  } cfg_scale_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  text_byte;
    logic        stop_cmd;
    logic        start_cmd;
    logic        update_targets;
    logic        telem_on;
    logic [15:0] speed_raw;
    logic [15:0] steer_raw;
    logic [31:0] drop_total;
    logic [2:0]  held_cnt;
    held_t       held;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL_SPD,
    BK_MUL_STR,
    BK_EMIT
  } back_state_t;

endpackage

FILE: sv/cfd_if.sv
// valid/ready channel interfaces for the deframer input and result beats
// no dependencies
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic       balance_active;

  modport source(output valid, op, rx_byte, balance_active, input ready);
  modport sink(input valid, op, rx_byte, balance_active, output ready);
endinterface

interface cfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  text_byte;
  logic        stop_cmd;
  logic        start_cmd;
  logic        update_targets;
  logic        telem_on;
  logic signed [31:0] speed_tgt;
  logic signed [31:0] steer;
  logic [31:0] drop_total;
  logic        last;

  modport source(output valid, kind, text_byte, stop_cmd, start_cmd, update_targets,
                 telem_on, speed_tgt, steer, drop_total, last, input ready);
  modport sink(input valid, kind, text_byte, stop_cmd, start_cmd, update_targets,
               telem_on, speed_tgt, steer, drop_total, last, output ready);
endinterface

FILE: sv/cfd_queue.sv
// two entry job queue between the deframer front and back
// depends on cfd_pkg
module cfd_queue
  import cfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_job
);

  localparam int QDEPTH = 2 ** QPTR_W;

  job_t mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: sv/cfd_front.sv
// front end: accepts bytes and ticks, tracks frame collection, queues jobs
// depends on cfd_pkg and cfd_if
module cfd_front
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_front_t cfg,
  cfd_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic        coll_r, coll_nxt;
  logic [2:0]  bc_r, bc_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [8:0]  el_r, el_nxt;
  logic [31:0] drop_r, drop_nxt;
  held_t       store_r;
  logic        store_we;
  logic        accept;
  logic [8:0]  el_sat;
  logic        frame_ok;
  logic [7:0]  flags;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign el_sat      = (el_r == '1) ? el_r : el_r + 9'd1;
  assign flags       = store_r[0];
  assign frame_ok    = (in_ch.rx_byte == cfg.footer_byte) && (store_r[HELD_LEN-1] == sum_r);

  always_comb begin
    coll_nxt = coll_r;
    bc_nxt   = bc_r;
    sum_nxt  = sum_r;
    el_nxt   = el_r;
    drop_nxt = drop_r;
    store_we = 1'b0;
    push     = 1'b0;
    push_job = '0;
    push_job.drop_total = drop_r;
    if (accept) begin
      if (in_ch.op == OP_TICK) begin
        if (coll_r) begin
          if (el_sat > {1'b0, cfg.timeout_ticks}) begin
            coll_nxt = 1'b0;
            bc_nxt   = '0;
            sum_nxt  = '0;
            el_nxt   = '0;
            drop_nxt = (drop_r == '1) ? drop_r : drop_r + 32'd1;
            push     = 1'b1;
            push_job.kind       = KIND_TIMEOUT;
            push_job.drop_total = drop_nxt;
            push_job.held_cnt   = bc_r;
            push_job.held       = store_r;
          end else begin
            el_nxt = el_sat;
          end
        end
      end else if (!coll_r) begin
        if (in_ch.rx_byte == cfg.header_byte) begin
          coll_nxt = 1'b1;
          bc_nxt   = '0;
          sum_nxt  = '0;
          el_nxt   = '0;
        end else begin
          push = 1'b1;
          push_job.kind      = KIND_TEXT;
          push_job.text_byte = in_ch.rx_byte;
        end
      end else begin
        if (bc_r < 3'(HELD_LEN)) begin
          store_we = 1'b1;
        end
        if (bc_r < 3'(SUM_LEN)) begin
          sum_nxt = sum_r + in_ch.rx_byte;
        end
        if (bc_r == 3'(HELD_LEN)) begin
          coll_nxt = 1'b0;
          bc_nxt   = '0;
          sum_nxt  = '0;
          el_nxt   = '0;
          push     = 1'b1;
          if (!frame_ok) begin
            push_job.kind = KIND_REJECT;
          end else begin
            push_job.kind = KIND_ACCEPT;
            if (flags[FLAG_ESTOP]) begin
              push_job.stop_cmd = 1'b1;
            end else begin
              push_job.stop_cmd       = !flags[FLAG_START] && in_ch.balance_active;
              push_job.start_cmd      = flags[FLAG_START] && !in_ch.balance_active;
              push_job.update_targets = 1'b1;
              push_job.telem_on       = flags[FLAG_TELEM];
              push_job.speed_raw      = {store_r[2], store_r[1]};
              push_job.steer_raw      = {store_r[4], store_r[3]};
            end
          end
        end else begin
          bc_nxt = bc_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[bc_r] <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coll_r <= 1'b0;
      bc_r   <= '0;
      sum_r  <= '0;
      el_r   <= '0;
      drop_r <= '0;
    end else begin
      coll_r <= coll_nxt;
      bc_r   <= bc_nxt;
      sum_r  <= sum_nxt;
      el_r   <= el_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

FILE: sv/cfd_back.sv
// back end: scales targets on a shared multiplier and emits result beats
// depends on cfd_pkg and cfd_if
module cfd_back
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_scale_t cfg,
  input  logic       q_empty,
  input  job_t       q_job,
  output logic       pop,
  cfd_out_if.source  out_ch
);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] spd_r, str_r;
  logic        load_spd, load_str;
  logic signed [15:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [40:0] prod;
  logic        is_last;
  logic [2:0]  byte_sel;

  assign prod     = mul_a * mul_b;
  assign is_last  = (idx_r == job_r.held_cnt);
  assign byte_sel = idx_r - 3'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_job.update_targets) ? BK_MUL_SPD : BK_EMIT;
        end
      end
      BK_MUL_SPD: state_nxt = BK_MUL_STR;
      BK_MUL_STR: state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (out_ch.ready && is_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state_r == BK_IDLE) && !q_empty;
    load_spd = (state_r == BK_MUL_SPD);
    load_str = (state_r == BK_MUL_STR);
    idx_nxt  = idx_r;
    if (pop) begin
      idx_nxt = '0;
    end else if (state_r == BK_EMIT && out_ch.ready && !is_last) begin
      idx_nxt = idx_r + 3'd1;
    end
    mul_a = load_str ? $signed(job_r.steer_raw) : $signed(job_r.speed_raw);
    mul_b = $signed({1'b0, (load_str ? cfg.steer_scale : cfg.speed_scale)});

    out_ch.valid          = (state_r == BK_EMIT);
    out_ch.drop_total     = job_r.drop_total;
    out_ch.last           = is_last;
    out_ch.kind           = job_r.kind;
    out_ch.text_byte      = job_r.text_byte;
    out_ch.stop_cmd       = job_r.stop_cmd;
    out_ch.start_cmd      = job_r.start_cmd;
    out_ch.update_targets = job_r.update_targets;
    out_ch.telem_on       = job_r.telem_on;
    out_ch.speed_tgt      = job_r.update_targets ? $signed(spd_r) : 32'sd0;
    out_ch.steer          = job_r.update_targets ? $signed(str_r) : 32'sd0;
    if (idx_r != '0) begin
      // replayed held byte after a timeout
      out_ch.kind      = KIND_TEXT;
      out_ch.text_byte = job_r.held[byte_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
    end
    if (load_spd) begin
      spd_r <= prod[39:8];
    end
    if (load_str) begin
      str_r <= prod[39:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

FILE: sv/control_frame_deframer.sv
// control frame deframer top level: configuration registers, front, queue, back
// depends on cfd_pkg, cfd_if, cfd_front, cfd_queue and cfd_back
//
// in_ch carries one beat per received serial byte (op 0) or per 1 ms tick (op 1).
// out_ch carries result beats: passed-through text, frame accepted, frame
// rejected, or frame timed out followed by the held bytes replayed as text;
// last marks the final beat caused by one input beat.
// cfg_we/cfg_index/cfg_data write header, footer, timeout and the two scales.
// Throughput: the front takes one input beat per cycle while its two-entry job
// queue has room. The back works on one job at a time: a text, rejected-frame
// or emergency-stop result is emitted directly once taken from the queue, an
// accepted frame that updates targets first forms two products (speed, then
// steer) on one shared 16x25 multiplier, and a timeout emits its result beat
// followed by one text beat per held byte.
// Reset (rst_n low, synchronous) returns to hunting for a header, clears the
// drop counter and loads the default registers.
// While out_ch.ready is low the current result holds; the queue fills and
// then in_ch.ready drops until the back moves on.
module control_frame_deframer
  import cfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  cfd_in_if.sink      in_ch,
  cfd_out_if.source   out_ch
);

  cfg_front_t cfg_front_r;
  cfg_scale_t cfg_scale_r;
  logic       q_full, q_empty, push, pop;
  job_t       push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_front_r.header_byte   <= HEADER_RST;
      cfg_front_r.footer_byte   <= FOOTER_RST;
      cfg_front_r.timeout_ticks <= TIMEOUT_RST;
      cfg_scale_r.speed_scale   <= SCALE_RST;
      cfg_scale_r.steer_scale   <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER:  cfg_front_r.header_byte   <= cfg_data[7:0];
        CFG_FOOTER:  cfg_front_r.footer_byte   <= cfg_data[7:0];
        CFG_TIMEOUT: cfg_front_r.timeout_ticks <= cfg_data[7:0];
        CFG_SPD_SCL: cfg_scale_r.speed_scale   <= cfg_data;
        CFG_STR_SCL: cfg_scale_r.steer_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  cfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_front_r),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  cfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  cfd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_scale_r),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
